// ===== hw/rtl/vrfs_pkg.sv =====
// Shared types, character codes and matcher functions for the variant record field scanner.
package vrfs_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] match_t;

  // Character codes used by the scanner.
  localparam byte_t CH_HASH  = 8'h23;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_EQ    = 8'h3D;
  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_S     = 8'h53;
  localparam byte_t CH_U     = 8'h55;
  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_V     = 8'h56;
  localparam byte_t CH_L     = 8'h4C;
  localparam byte_t CH_E     = 8'h45;
  localparam byte_t CH_N     = 8'h4E;
  localparam byte_t CH_D     = 8'h44;
  localparam byte_t CH_I     = 8'h49;

  // Pattern lengths.
  localparam match_t SUP_LEN   = 3'd4;
  localparam match_t SVLEN_LEN = 3'd6;
  localparam match_t TAG_LEN   = 3'd5;
  localparam int     NUM_TAGS  = 3;

  // Tag indexes, in priority order.
  localparam logic [1:0] TAG_DEL = 2'd0;
  localparam logic [1:0] TAG_INS = 2'd1;
  localparam logic [1:0] TAG_INV = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_INS  = 2'd2;
  localparam logic [1:0] KIND_INV  = 2'd3;

  // Number magnitude saturates at 2^31 so that the negative limit is exact.
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_KEY,    // waiting for the key
    PH_SPACE,  // key seen, skipping leading white space
    PH_SIGN,   // sign taken, digits must follow
    PH_DIGIT,  // inside the digit run
    PH_DONE    // number finished
  } num_phase_t;

  // Per-byte controls from the top level to a number parser.
  typedef struct packed {
    logic take;     // a byte is accepted this cycle
    logic clear;    // that byte ends the record
    logic key_hit;  // the key matcher completes on that byte
  } scan_ctl_t;

  function automatic byte_t sup_char(match_t k);
    byte_t c;
    case (k)
      3'd0:    c = CH_S;
      3'd1:    c = CH_U;
      3'd2:    c = CH_P;
      3'd3:    c = CH_EQ;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic byte_t svlen_char(match_t k);
    byte_t c;
    case (k)
      3'd0:    c = CH_S;
      3'd1:    c = CH_V;
      3'd2:    c = CH_L;
      3'd3:    c = CH_E;
      3'd4:    c = CH_N;
      3'd5:    c = CH_EQ;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic byte_t tag_char(logic [1:0] t, match_t k);
    byte_t c;
    c = 8'h00;
    case (k)
      3'd0: c = CH_LT;
      3'd1: begin
        case (t)
          TAG_DEL: c = CH_D;
          default: c = CH_I;
        endcase
      end
      3'd2: begin
        case (t)
          TAG_DEL: c = CH_E;
          default: c = CH_N;
        endcase
      end
      3'd3: begin
        case (t)
          TAG_DEL: c = CH_L;
          TAG_INS: c = CH_S;
          default: c = CH_V;
        endcase
      end
      3'd4:    c = CH_GT;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // One matcher step. On a mismatch the byte is rechecked as a first character.
  function automatic match_t advance(match_t k, match_t len, byte_t expect_ch,
                                     byte_t first_ch, byte_t ch);
    match_t r;
    if (k < len && ch == expect_ch) begin
      r = k + 3'd1;
    end else if (ch == first_ch) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vrfs_num_parser.sv =====
// Signed decimal parser that follows one key, in the manner of atoi, with saturation.
module vrfs_num_parser
  import vrfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  scan_ctl_t          ctl,
  input  byte_t              text_byte,
  output logic               idle,       // still waiting for the key
  output logic signed [31:0] value_upd   // value including the current byte
);

  num_phase_t  phase_r, phase_nxt, phase_upd;
  logic        neg_r, neg_nxt, neg_upd;
  logic [31:0] mag_r, mag_nxt, mag_upd;

  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic [34:0] prod;
  logic [31:0] mag_dig;

  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_space = (text_byte == CH_SPACE) ||
                    ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign is_sign  = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);

  // mag * 10 + digit, clamped at 2^31.
  assign prod    = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0} + {31'd0, text_byte[3:0]};
  assign mag_dig = (prod > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];

  assign idle = (phase_r == PH_KEY);

  // Phase sequencing.
  always_comb begin
    phase_upd = phase_r;
    case (phase_r)
      PH_KEY: begin
        if (ctl.key_hit) begin
          phase_upd = PH_SPACE;
        end
      end
      PH_SPACE: begin
        if (is_sign) begin
          phase_upd = PH_SIGN;
        end else if (is_digit) begin
          phase_upd = PH_DIGIT;
        end else if (!is_space) begin
          phase_upd = PH_DONE;
        end
      end
      PH_SIGN, PH_DIGIT: begin
        phase_upd = is_digit ? PH_DIGIT : PH_DONE;
      end
      default: phase_upd = phase_r;
    endcase

    if (!ctl.take) begin
      phase_nxt = phase_r;
    end else if (ctl.clear) begin
      phase_nxt = PH_KEY;
    end else begin
      phase_nxt = phase_upd;
    end
  end

  // Sign and magnitude.
  always_comb begin
    neg_upd = neg_r;
    mag_upd = mag_r;
    case (phase_r)
      PH_SPACE: begin
        if (is_sign) begin
          neg_upd = (text_byte == CH_MINUS);
        end else if (is_digit) begin
          mag_upd = mag_dig;
        end
      end
      PH_SIGN, PH_DIGIT: begin
        if (is_digit) begin
          mag_upd = mag_dig;
        end
      end
      default: begin
        neg_upd = neg_r;
        mag_upd = mag_r;
      end
    endcase

    if (!ctl.take) begin
      neg_nxt = neg_r;
      mag_nxt = mag_r;
    end else if (ctl.clear) begin
      neg_nxt = 1'b0;
      mag_nxt = '0;
    end else begin
      neg_nxt = neg_upd;
      mag_nxt = mag_upd;
    end
  end

  always_comb begin
    if (neg_upd) begin
      value_upd = $signed(32'd0 - mag_upd);
    end else if (mag_upd[31]) begin
      value_upd = $signed(POS_MAX);
    end else begin
      value_upd = $signed(mag_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      neg_r   <= 1'b0;
      mag_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
    end
  end

endmodule

// ===== hw/rtl/variant_record_field_scanner.sv =====
// Top level of the variant record field scanner: matchers, header flag and result register.
//
// The block reads one text record a byte at a time on the in_ stream: in_tdata carries the
// character and in_tlast marks the last byte of the record. It looks for the first "SUP="
// and the first "SVLEN=" and parses the signed decimal after each, notes whether "<DEL>",
// "<INS>" or "<INV>" occurs (DEL first, then INS, then INV), and flags records that begin
// with '#'. One result item leaves on the out_ stream for each record, in the cycle after its
// last byte is accepted; bytes that are not last produce nothing.
// Every byte is handled in the cycle it is accepted, so the block takes one byte per cycle
// unless a last byte is held off. The result waits in an output register. While it waits,
// further bytes of the next record are still accepted; only a last byte is held off, and
// only while the previous result is still untaken and out_tready is low.
// Synchronous reset (rst_n low) clears all matchers, parsers and the output valid; the
// next accepted byte is treated as the first byte of a record.
module variant_record_field_scanner
  import vrfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] support_value, [63:32] length_value
  output logic [2:0]  out_tuser   // [0] is_header, [2:1] call_kind
);

  logic take;
  logic last_take;
  logic out_free;

  // The output register can take a new result when empty or being drained this cycle.
  assign out_free  = !out_tvalid || out_tready;
  assign in_tready = out_free || !in_tlast;
  assign take      = in_tvalid && in_tready;
  assign last_take = take && in_tlast;

  // Header detection on the first byte of each record.
  logic first_r, first_nxt;
  logic header_r, header_nxt, header_upd;

  assign header_upd = first_r ? (in_tdata == CH_HASH) : header_r;

  always_comb begin
    first_nxt  = first_r;
    header_nxt = header_r;
    if (last_take) begin
      first_nxt  = 1'b1;
      header_nxt = 1'b0;
    end else if (take) begin
      first_nxt  = 1'b0;
      header_nxt = header_upd;
    end
  end

  // Key matchers. Each runs only until its parser has seen the key.
  match_t sup_match_r, sup_match_nxt, sup_step;
  match_t svlen_match_r, svlen_match_nxt, svlen_step;
  logic   sup_idle, svlen_idle;
  logic   sup_hit, svlen_hit;

  assign sup_step   = advance(sup_match_r, SUP_LEN, sup_char(sup_match_r), CH_S, in_tdata);
  assign svlen_step = advance(svlen_match_r, SVLEN_LEN, svlen_char(svlen_match_r), CH_S,
                              in_tdata);
  assign sup_hit    = sup_idle && (sup_step == SUP_LEN);
  assign svlen_hit  = svlen_idle && (svlen_step == SVLEN_LEN);

  always_comb begin
    sup_match_nxt   = sup_match_r;
    svlen_match_nxt = svlen_match_r;
    if (last_take) begin
      sup_match_nxt   = '0;
      svlen_match_nxt = '0;
    end else if (take) begin
      if (sup_idle) begin
        sup_match_nxt = sup_hit ? 3'd0 : sup_step;
      end
      if (svlen_idle) begin
        svlen_match_nxt = svlen_hit ? 3'd0 : svlen_step;
      end
    end
  end

  // Tag matchers, one per tag, each restarting after a full match.
  match_t          tag_match_r [NUM_TAGS];
  match_t          tag_match_nxt [NUM_TAGS];
  match_t          tag_step [NUM_TAGS];
  logic [NUM_TAGS-1:0] tag_hit;
  logic [NUM_TAGS-1:0] found_r, found_nxt, found_upd;

  always_comb begin
    for (int t = 0; t < NUM_TAGS; t++) begin
      tag_step[t] = advance(tag_match_r[t], TAG_LEN, tag_char(2'(t), tag_match_r[t]), CH_LT,
                            in_tdata);
      tag_hit[t]  = (tag_step[t] == TAG_LEN);
      if (last_take) begin
        tag_match_nxt[t] = '0;
      end else if (take) begin
        tag_match_nxt[t] = tag_hit[t] ? 3'd0 : tag_step[t];
      end else begin
        tag_match_nxt[t] = tag_match_r[t];
      end
    end
  end

  assign found_upd = found_r | tag_hit;

  always_comb begin
    if (last_take) begin
      found_nxt = '0;
    end else if (take) begin
      found_nxt = found_upd;
    end else begin
      found_nxt = found_r;
    end
  end

  logic [1:0] kind_upd;

  always_comb begin
    if (found_upd[TAG_DEL]) begin
      kind_upd = KIND_DEL;
    end else if (found_upd[TAG_INS]) begin
      kind_upd = KIND_INS;
    end else if (found_upd[TAG_INV]) begin
      kind_upd = KIND_INV;
    end else begin
      kind_upd = KIND_NONE;
    end
  end

  // Number parsers behind each key.
  scan_ctl_t          sup_ctl, svlen_ctl;
  logic signed [31:0] sup_value, svlen_value;

  assign sup_ctl   = '{take: take, clear: in_tlast, key_hit: sup_hit};
  assign svlen_ctl = '{take: take, clear: in_tlast, key_hit: svlen_hit};

  vrfs_num_parser u_sup_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sup_ctl),
    .text_byte (in_tdata),
    .idle      (sup_idle),
    .value_upd (sup_value)
  );

  vrfs_num_parser u_svlen_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (svlen_ctl),
    .text_byte (in_tdata),
    .idle      (svlen_idle),
    .value_upd (svlen_value)
  );

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (last_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {svlen_value, sup_value};
      out_user_nxt  = {kind_upd, header_upd};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r       <= 1'b1;
      header_r      <= 1'b0;
      sup_match_r   <= '0;
      svlen_match_r <= '0;
      found_r       <= '0;
      out_valid_r   <= 1'b0;
      for (int t = 0; t < NUM_TAGS; t++) begin
        tag_match_r[t] <= '0;
      end
    end else begin
      first_r       <= first_nxt;
      header_r      <= header_nxt;
      sup_match_r   <= sup_match_nxt;
      svlen_match_r <= svlen_match_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
      for (int t = 0; t < NUM_TAGS; t++) begin
        tag_match_r[t] <= tag_match_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

// ===== verif/variant_record_field_scanner_tb.sv =====
// Self-checking testbench for the variant record field scanner: record stimulus and predictor.
module variant_record_field_scanner_tb
  import vrfs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // White space codes that the package does not name.
  localparam byte_t CH_LF = 8'h0A;
  localparam byte_t CH_VT = 8'h0B;
  localparam byte_t CH_FF = 8'h0C;

  // The run is stopped here if the block stalls; the slowest correct run is far shorter.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Bytes per idling phase, three phases in all.
  localparam int PHASE_BYTES = 250;

  // Progress of one "KEY=" number parser.
  typedef struct {
    logic [2:0]  hits;   // key characters matched so far
    num_phase_t  phase;
    logic        neg;
    logic [31:0] mag;    // saturates at 2^31
  } number_scan_t;

  // What the block should report for one record.
  typedef struct {
    logic        header;
    logic [1:0]  kind;
    logic [31:0] support;
    logic [31:0] length;
  } record_result_t;

  // Tracks the record being scanned and holds the results still owed by the block.
  class record_checker;
    string          tag_text[3];
    logic           at_line_start;
    logic           header_seen;
    number_scan_t   sup_scan;
    number_scan_t   svlen_scan;
    int             tag_hits[3];
    logic [2:0]     tags_found;
    record_result_t pending_records[$];
    int             errors;

    function new();
      tag_text[TAG_DEL] = "<DEL>";
      tag_text[TAG_INS] = "<INS>";
      tag_text[TAG_INV] = "<INV>";
      errors = 0;
      clear_record();
    endfunction

    function void clear_record();
      at_line_start = 1'b1;
      header_seen   = 1'b0;
      sup_scan      = '{hits: 3'd0, phase: PH_KEY, neg: 1'b0, mag: 32'd0};
      svlen_scan    = sup_scan;
      tag_hits      = '{0, 0, 0};
      tags_found    = 3'b000;
    endfunction

    // A mismatching byte may still start the pattern again.
    function int next_hits(int k, string pat, byte_t c);
      if (k < pat.len() && c == pat[k]) return k + 1;
      return (c == pat[0]) ? 1 : 0;
    endfunction

    function bit is_blank(byte_t c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
             c == CH_CR;
    endfunction

    function number_scan_t take_digit(number_scan_t f, byte_t c);
      logic [35:0] m;
      m = 36'(f.mag) * 36'd10 + 36'(c - CH_ZERO);
      f.mag   = (m > 36'(MAG_LIMIT)) ? MAG_LIMIT : m[31:0];
      f.phase = PH_DIGIT;
      return f;
    endfunction

    // Only the first occurrence of the key counts; after that the parser runs like atoi.
    function number_scan_t scan_number(number_scan_t f, string key, byte_t c);
      logic digit;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      case (f.phase)
        PH_KEY: begin
          f.hits = 3'(next_hits(f.hits, key, c));
          if (f.hits == key.len()) begin
            f.hits  = 3'd0;
            f.phase = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (!is_blank(c)) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              f.neg   = (c == CH_MINUS);
              f.phase = PH_SIGN;
            end else if (digit) begin
              f = take_digit(f, c);
            end else begin
              f.phase = PH_DONE;
            end
          end
        end
        PH_SIGN, PH_DIGIT: begin
          if (digit) f = take_digit(f, c);
          else f.phase = PH_DONE;
        end
        default: ;
      endcase
      return f;
    endfunction

    function logic [31:0] number_value(number_scan_t f);
      if (f.neg) return 32'd0 - f.mag;
      return (f.mag > POS_MAX) ? POS_MAX : f.mag;
    endfunction

    // Called for every accepted input item.
    function void note_byte(byte_t c, logic last);
      record_result_t r;
      if (at_line_start) begin
        header_seen   = (c == CH_HASH);
        at_line_start = 1'b0;
      end
      sup_scan   = scan_number(sup_scan, "SUP=", c);
      svlen_scan = scan_number(svlen_scan, "SVLEN=", c);
      for (int t = 0; t < NUM_TAGS; t++) begin
        tag_hits[t] = next_hits(tag_hits[t], tag_text[t], c);
        if (tag_hits[t] == tag_text[t].len()) begin
          tags_found[t] = 1'b1;
          tag_hits[t]   = 0;
        end
      end
      if (last) begin
        r.header = header_seen;
        if (tags_found[TAG_DEL]) r.kind = KIND_DEL;
        else if (tags_found[TAG_INS]) r.kind = KIND_INS;
        else if (tags_found[TAG_INV]) r.kind = KIND_INV;
        else r.kind = KIND_NONE;
        r.support = number_value(sup_scan);
        r.length  = number_value(svlen_scan);
        pending_records.push_back(r);
        clear_record();
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [63:0] data, logic [2:0] user);
      record_result_t r;
      if (pending_records.size() == 0) begin
        $error("result item arrived with no record pending");
        errors++;
        return;
      end
      r = pending_records.pop_front();
      check_field("is_header", 32'(r.header), 32'(user[0]));
      check_field("call_kind", 32'(r.kind), 32'(user[2:1]));
      check_field("support_value", r.support, data[31:0]);
      check_field("length_value", r.length, data[63:32]);
    endfunction

    function void report_leftover();
      if (pending_records.size() != 0) begin
        $error("%0d record results never arrived", pending_records.size());
        errors += pending_records.size();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;   // [31:0] support_value, [63:32] length_value
  logic [2:0]  out_tuser;   // [0] is_header, [2:1] call_kind

  record_checker record_sb;
  byte_t         record_text[$];
  int            tx_idle_pct = 12;
  int            rx_idle_pct = 80;
  int            bytes_sent = 0;
  int            phase_start;
  int unsigned   cycle_count = 0;

  variant_record_field_scanner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random; the percentage changes with the phase of the run.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Both channels are sampled at the clock edge, so the values seen here are the ones
  // the block saw. A result from an earlier record is checked before the byte of the
  // same cycle is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) record_sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) record_sb.note_byte(in_tdata, in_tlast);
    end
  end

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) record_text.push_back(s[i]);
  endfunction

  function byte_t pick_blank();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Optional white space, optional sign, then digits; now and then a value at or past
  // the 32-bit limits, and sometimes no digits at all.
  function void push_number();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) record_text.push_back(pick_blank());
    end
    case ($urandom_range(3))
      0:       record_text.push_back(CH_PLUS);
      1:       record_text.push_back(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(5) == 0) begin
      case ($urandom_range(3))
        0:       push_text("2147483647");
        1:       push_text("2147483648");
        2:       push_text("2147483649");
        default: push_text("99999999999");
      endcase
    end else begin
      repeat ($urandom_range(0, 7)) record_text.push_back(byte_t'(CH_ZERO + $urandom_range(9)));
    end
  endfunction

  // Most of a record is well-formed keys with numbers and tags; the rest is partial
  // patterns and raw bytes that exercise the matcher restart.
  function void build_record();
    record_text.delete();
    if ($urandom_range(7) == 0) record_text.push_back(CH_HASH);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(11))
        0, 1, 2: begin
          if ($urandom_range(3) == 0) push_text("S");
          push_text("SUP=");
          push_number();
        end
        3, 4, 5: begin
          if ($urandom_range(3) == 0) push_text("S");
          push_text("SVLEN=");
          push_number();
        end
        6: begin
          case ($urandom_range(4))
            0:       push_text("SU");
            1:       push_text("SUP");
            2:       push_text("SVL");
            3:       push_text("SVLEN");
            default: push_text("SSV");
          endcase
        end
        7, 8: begin
          case ($urandom_range(2))
            0:       push_text("<DEL>");
            1:       push_text("<INS>");
            default: push_text("<INV>");
          endcase
        end
        9: begin
          case ($urandom_range(3))
            0:       push_text("<IN");
            1:       push_text("<DE");
            2:       push_text("<<DEL>");
            default: push_text("<INV");
          endcase
        end
        10: record_text.push_back(byte_t'($urandom_range(255)));
        default: begin
          if ($urandom_range(1) == 0) push_text(";");
          else push_number();
        end
      endcase
    end
    if (record_text.size() == 0) record_text.push_back(byte_t'($urandom_range(255)));
  endfunction

  // Offers one item, with random idle cycles ahead of it, and returns at the edge
  // where it is taken.
  task automatic send_byte(input byte_t c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_record();
    for (int i = 0; i < record_text.size(); i++) begin
      send_byte(record_text[i], i == record_text.size() - 1);
    end
    bytes_sent += record_text.size();
  endtask

  initial begin
    record_sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 80;
        end
        1: begin
          tx_idle_pct = 80;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // Header line, a key that only matches after a restart, a tab before the sign,
        // a negative overflow and an inversion tag, all in one record.
        record_text.delete();
        push_text("#SSUP=\t-3000000000<INV>");
        send_record();
        // Single-byte records with the lowest and the highest byte value.
        record_text.delete();
        record_text.push_back(8'h00);
        send_record();
        record_text.delete();
        record_text.push_back(8'hFF);
        send_record();
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_record();
        send_record();
      end
    end
    in_tvalid <= 1'b0;

    // Drain: the last result is offered in the cycle after its last byte, plus receiver stalls.
    while (record_sb.pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    record_sb.report_leftover();
    if (record_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== variant_record_field_scanner.f =====
hw/rtl/vrfs_pkg.sv
hw/rtl/vrfs_num_parser.sv
hw/rtl/variant_record_field_scanner.sv
verif/variant_record_field_scanner_tb.sv
